// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// No dependencies; set NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("scheduler assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("scheduler forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== hw/rtl/rrts_pkg.sv =====
// Types and constants of the round robin thread scheduler.
// No dependencies; used by rrts_cell, rrts_seq and the top level.
`timescale 1ns / 1ps

package rrts_pkg;

    // Width of thread ids on the ports.
    localparam int TID_W = 3;

    // Run state of one thread slot.
    typedef enum logic [2:0] {
        SLOT_UNUSED   = 3'd0,
        SLOT_RUNNABLE = 3'd1,
        SLOT_RUNNING  = 3'd2,
        SLOT_SLEEPING = 3'd3,
        SLOT_EXITED   = 3'd4
    } slot_state_t;

    // Operation carried by an input word.
    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_YIELD  = 2'd1,
        OP_JOIN   = 2'd2,
        OP_EXIT   = 2'd3
    } op_t;

    // Command broadcast to the row of cells.
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_SET   = 3'd1,
        CMD_CLAIM = 3'd2,
        CMD_SLEEP = 3'd3,
        CMD_EXIT  = 3'd4
    } cell_cmd_t;

    // Control bundle from the sequencer to every cell.
    typedef struct packed {
        cell_cmd_t   cmd;
        slot_state_t new_state;
        slot_state_t query;
        logic        use_token;
        logic        cond;
        logic        load_token;
        logic        advance_token;
    } cell_ctl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CHECK_CUR = 3'd1,
        ST_CHECK_TGT = 3'd2,
        ST_ACT       = 3'd3,
        ST_SCAN_FREE = 3'd4,
        ST_SCAN_RUN  = 3'd5,
        ST_FINISH    = 3'd6
    } seq_state_t;

endpackage

// ===== hw/rtl/round_robin_thread_scheduler_core.sv =====
// Top level of the round robin thread scheduler: cell ring plus sequencer.
// Depends on rrts_pkg, rrts_cell, rrts_seq and assert_macros.svh.
//
// Usage: each word on the s_ channel (s_func, s_target_thread) is one
// scheduling event: create, yield, join or exit of the current thread.
// Each event gives exactly one word on the m_ channel with the thread that
// runs afterwards, the slot claimed by create and the two status flags.
// Both channels use valid/ready; a word moves when both are high.
// One event is worked on at a time. After acceptance come the checks and
// the update, then (unless a join ends early on a target that has exited or
// is out of range) a token walk along the ring of slot cells over at most
// THREAD_COUNT cells, then the output register is loaded, and the next word
// is accepted in the cycle after the result is loaded. The token walk moves
// one cell per cycle.
// Reset (aresetn low, synchronous) leaves slot 0 running as the current
// thread and every other slot unused, with no result pending.
// If the receiver stalls, the result waits in the output register and the
// next event is still accepted; it then waits to load its own result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module round_robin_thread_scheduler_core #(
    parameter int THREAD_COUNT = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [rrts_pkg::TID_W-1:0] s_target_thread,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rrts_pkg::TID_W-1:0] m_running_thread,
    output logic [rrts_pkg::TID_W-1:0] m_new_thread,
    output logic                       m_create_ok,
    output logic                       m_none_runnable
);

    localparam int ID_W = $clog2(THREAD_COUNT);

    rrts_pkg::cell_ctl_t     ctl;
    logic [ID_W-1:0]         sel_id;
    logic [ID_W-1:0]         start_id;
    logic [ID_W-1:0]         cur_id;
    logic [ID_W-1:0]         arg_id;
    logic [THREAD_COUNT-1:0] sel_vec;
    logic [THREAD_COUNT-1:0] start_vec;
    logic [THREAD_COUNT-1:0] tokens;
    logic [THREAD_COUNT-1:0] hits;
    logic [THREAD_COUNT-1:0] runs;
    logic                    hit;

    // Event sequencer and output register.
    rrts_seq #(
        .THREAD_COUNT(THREAD_COUNT),
        .ID_W(ID_W)
    ) u_seq (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_target_thread(s_target_thread),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_running_thread(m_running_thread),
        .m_new_thread(m_new_thread),
        .m_create_ok(m_create_ok),
        .m_none_runnable(m_none_runnable),
        .hit(hit),
        .ctl(ctl),
        .sel_id(sel_id),
        .start_id(start_id),
        .cur_id(cur_id),
        .arg_id(arg_id)
    );

    // Ring of slot cells; each takes the token from the cell below it.
    for (genvar i = 0; i < THREAD_COUNT; i++) begin : g_cell
        assign sel_vec[i]   = (sel_id == ID_W'(i));
        assign start_vec[i] = (start_id == ID_W'(i));

        rrts_cell #(
            .ID_W(ID_W),
            .BOOT_RUNNING(i == 0)
        ) u_cell (
            .aclk(aclk),
            .aresetn(aresetn),
            .ctl(ctl),
            .sel_in(sel_vec[i]),
            .token_init(start_vec[i]),
            .token_in(tokens[(i + THREAD_COUNT - 1) % THREAD_COUNT]),
            .cur_id(cur_id),
            .arg_id(arg_id),
            .token_out(tokens[i]),
            .hit(hits[i]),
            .running(runs[i])
        );
    end

    // Only the cell in focus can answer a query.
    assign hit = |hits;

    // At most one cell answers, one holds the token and one thread runs.
    `ASSERT_CLK(a_hit_single, aclk, aresetn, $onehot0(hits))
    `ASSERT_CLK(a_token_single, aclk, aresetn, $onehot0(tokens))
    `ASSERT_CLK(a_running_single, aclk, aresetn, $onehot0(runs))

endmodule

// ===== hw/rtl/rrts_cell.sv =====
// One thread slot of the scheduler: run state, wait link and scan token.
// Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_cell #(
    parameter int ID_W         = 3,
    parameter bit BOOT_RUNNING = 1'b0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rrts_pkg::cell_ctl_t ctl,
    input  logic                sel_in,
    input  logic                token_init,
    input  logic                token_in,
    input  logic [ID_W-1:0]     cur_id,
    input  logic [ID_W-1:0]     arg_id,
    output logic                token_out,
    output logic                hit,
    output logic                running
);

    rrts_pkg::slot_state_t state_reg, state_next;
    logic                  wait_valid_reg, wait_valid_next;
    logic [ID_W-1:0]       wait_id_reg, wait_id_next;
    logic                  token_reg, token_next;
    logic                  focus;
    logic                  match;
    logic                  apply;

    // The cell in focus is either the token holder or the addressed slot.
    assign focus   = ctl.use_token ? token_reg : sel_in;
    assign match   = (state_reg == ctl.query);
    assign apply   = focus && (!ctl.cond || match);
    assign hit     = focus && match;
    assign running = (state_reg == rrts_pkg::SLOT_RUNNING);
    assign token_out = token_reg;

    // Apply the broadcast command to this slot.
    always_comb begin
        state_next      = state_reg;
        wait_valid_next = wait_valid_reg;
        wait_id_next    = wait_id_reg;
        case (ctl.cmd)
            rrts_pkg::CMD_SET: begin
                if (apply) begin
                    state_next = ctl.new_state;
                end
            end
            rrts_pkg::CMD_CLAIM: begin
                if (apply) begin
                    state_next      = ctl.new_state;
                    wait_valid_next = 1'b0;
                    wait_id_next    = '0;
                end
            end
            rrts_pkg::CMD_SLEEP: begin
                if (apply) begin
                    state_next      = rrts_pkg::SLOT_SLEEPING;
                    wait_valid_next = 1'b1;
                    wait_id_next    = arg_id;
                end
            end
            rrts_pkg::CMD_EXIT: begin
                if (apply) begin
                    state_next = rrts_pkg::SLOT_EXITED;
                end
                // Every slot waiting on the exiting thread wakes up.
                if (wait_valid_reg && (wait_id_reg == cur_id)) begin
                    state_next      = rrts_pkg::SLOT_RUNNABLE;
                    wait_valid_next = 1'b0;
                    wait_id_next    = '0;
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase
    end

    // The scan token is loaded at the start slot, then handed along the ring.
    always_comb begin
        token_next = token_reg;
        if (ctl.load_token) begin
            token_next = token_init;
        end else if (ctl.advance_token) begin
            token_next = token_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BOOT_RUNNING ? rrts_pkg::SLOT_RUNNING : rrts_pkg::SLOT_UNUSED;
            wait_valid_reg <= 1'b0;
            token_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wait_valid_reg <= wait_valid_next;
            token_reg      <= token_next;
        end
    end

    always_ff @(posedge aclk) begin
        wait_id_reg <= wait_id_next;
    end

endmodule

// ===== hw/rtl/rrts_seq.sv =====
// Event sequencer of the scheduler: handshakes, per-event steps, result word.
// Depends on rrts_pkg; drives the row of rrts_cell instances.
`timescale 1ns / 1ps

module rrts_seq #(
    parameter int THREAD_COUNT = 8,
    parameter int ID_W         = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [rrts_pkg::TID_W-1:0] s_target_thread,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rrts_pkg::TID_W-1:0] m_running_thread,
    output logic [rrts_pkg::TID_W-1:0] m_new_thread,
    output logic                       m_create_ok,
    output logic                       m_none_runnable,
    input  logic                       hit,
    output rrts_pkg::cell_ctl_t        ctl,
    output logic [ID_W-1:0]            sel_id,
    output logic [ID_W-1:0]            start_id,
    output logic [ID_W-1:0]            cur_id,
    output logic [ID_W-1:0]            arg_id
);

    localparam logic [ID_W-1:0] LAST_ID = ID_W'(THREAD_COUNT - 1);

    rrts_pkg::seq_state_t       state_reg, state_next;
    rrts_pkg::op_t              op_reg, op_next;
    logic [rrts_pkg::TID_W-1:0] target_reg, target_next;
    logic [ID_W-1:0]            cur_reg, cur_next;
    logic                       cur_run_reg, cur_run_next;
    logic [ID_W-1:0]            idx_reg, idx_next;
    logic [ID_W-1:0]            step_reg, step_next;
    logic [ID_W-1:0]            new_slot_reg, new_slot_next;
    logic                       ok_reg, ok_next;
    logic                       none_reg, none_next;
    logic                       m_valid_reg, m_valid_next;
    logic [rrts_pkg::TID_W-1:0] m_running_reg, m_running_next;
    logic [rrts_pkg::TID_W-1:0] m_new_reg, m_new_next;
    logic                       m_ok_reg, m_ok_next;
    logic                       m_none_reg, m_none_next;
    logic [ID_W-1:0]            cur_inc;
    logic [ID_W-1:0]            idx_inc;
    logic                       in_range;
    logic                       out_free;
    logic                       scan_last;

    assign cur_inc   = (cur_reg == LAST_ID) ? '0 : cur_reg + 1'b1;
    assign idx_inc   = (idx_reg == LAST_ID) ? '0 : idx_reg + 1'b1;
    assign in_range  = ({4'b0000, target_reg} < 7'(THREAD_COUNT));
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_last = (step_reg == LAST_ID);
    assign cur_id    = cur_reg;
    assign arg_id    = ID_W'(target_reg);

    assign m_valid          = m_valid_reg;
    assign m_running_thread = m_running_reg;
    assign m_new_thread     = m_new_reg;
    assign m_create_ok      = m_ok_reg;
    assign m_none_runnable  = m_none_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rrts_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rrts_pkg::ST_CHECK_CUR;
                end
            end
            rrts_pkg::ST_CHECK_CUR: begin
                unique case (op_reg)
                    rrts_pkg::OP_CREATE: state_next = rrts_pkg::ST_SCAN_FREE;
                    rrts_pkg::OP_JOIN:   state_next = rrts_pkg::ST_CHECK_TGT;
                    rrts_pkg::OP_YIELD:  state_next = rrts_pkg::ST_ACT;
                    rrts_pkg::OP_EXIT:   state_next = rrts_pkg::ST_ACT;
                    default:             state_next = rrts_pkg::ST_ACT;
                endcase
            end
            rrts_pkg::ST_CHECK_TGT: begin
                if (!cur_run_reg) begin
                    state_next = rrts_pkg::ST_SCAN_RUN;
                end else if (in_range && !hit) begin
                    state_next = rrts_pkg::ST_ACT;
                end else begin
                    state_next = rrts_pkg::ST_FINISH;
                end
            end
            rrts_pkg::ST_ACT: begin
                state_next = rrts_pkg::ST_SCAN_RUN;
            end
            rrts_pkg::ST_SCAN_FREE, rrts_pkg::ST_SCAN_RUN: begin
                if (hit || scan_last) begin
                    state_next = rrts_pkg::ST_FINISH;
                end
            end
            rrts_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = rrts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrts_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath next values.
    always_comb begin
        s_ready           = 1'b0;
        ctl.cmd           = rrts_pkg::CMD_NONE;
        ctl.new_state     = rrts_pkg::SLOT_UNUSED;
        ctl.query         = rrts_pkg::SLOT_UNUSED;
        ctl.use_token     = 1'b0;
        ctl.cond          = 1'b0;
        ctl.load_token    = 1'b0;
        ctl.advance_token = 1'b0;
        sel_id            = cur_reg;
        start_id          = cur_inc;
        op_next           = op_reg;
        target_next       = target_reg;
        cur_next          = cur_reg;
        cur_run_next      = cur_run_reg;
        idx_next          = idx_reg;
        step_next         = step_reg;
        new_slot_next     = new_slot_reg;
        ok_next           = ok_reg;
        none_next         = none_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_running_next    = m_running_reg;
        m_new_next        = m_new_reg;
        m_ok_next         = m_ok_reg;
        m_none_next       = m_none_reg;
        unique case (state_reg)
            rrts_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                op_next     = rrts_pkg::op_t'(s_func);
                target_next = s_target_thread;
            end
            rrts_pkg::ST_CHECK_CUR: begin
                // Is the current thread running? Also place the scan token.
                ctl.query      = rrts_pkg::SLOT_RUNNING;
                ctl.load_token = 1'b1;
                if (op_reg == rrts_pkg::OP_CREATE) begin
                    start_id = '0;
                end
                cur_run_next  = hit;
                idx_next      = start_id;
                step_next     = '0;
                new_slot_next = '0;
                ok_next       = 1'b0;
                none_next     = 1'b0;
            end
            rrts_pkg::ST_CHECK_TGT: begin
                // Has the join target exited?
                sel_id    = arg_id;
                ctl.query = rrts_pkg::SLOT_EXITED;
            end
            rrts_pkg::ST_ACT: begin
                unique case (op_reg)
                    rrts_pkg::OP_YIELD: begin
                        if (cur_run_reg) begin
                            ctl.cmd       = rrts_pkg::CMD_SET;
                            ctl.new_state = rrts_pkg::SLOT_RUNNABLE;
                        end
                    end
                    rrts_pkg::OP_JOIN: begin
                        ctl.cmd = rrts_pkg::CMD_SLEEP;
                    end
                    rrts_pkg::OP_EXIT: begin
                        if (cur_run_reg) begin
                            ctl.cmd = rrts_pkg::CMD_EXIT;
                        end
                    end
                    default: begin
                        ctl.cmd = rrts_pkg::CMD_NONE;
                    end
                endcase
            end
            rrts_pkg::ST_SCAN_FREE: begin
                // Lowest unused slot, claimed by the cell that finds it.
                ctl.cmd           = rrts_pkg::CMD_CLAIM;
                ctl.new_state     = rrts_pkg::SLOT_RUNNABLE;
                ctl.query         = rrts_pkg::SLOT_UNUSED;
                ctl.use_token     = 1'b1;
                ctl.cond          = 1'b1;
                ctl.advance_token = 1'b1;
                idx_next          = idx_inc;
                step_next         = step_reg + 1'b1;
                if (hit) begin
                    new_slot_next = idx_reg;
                    ok_next       = 1'b1;
                end
            end
            rrts_pkg::ST_SCAN_RUN: begin
                // First runnable slot after the current one, current one last.
                ctl.cmd           = rrts_pkg::CMD_SET;
                ctl.new_state     = rrts_pkg::SLOT_RUNNING;
                ctl.query         = rrts_pkg::SLOT_RUNNABLE;
                ctl.use_token     = 1'b1;
                ctl.cond          = 1'b1;
                ctl.advance_token = 1'b1;
                idx_next          = idx_inc;
                step_next         = step_reg + 1'b1;
                if (hit) begin
                    cur_next = idx_reg;
                end else if (scan_last) begin
                    none_next = 1'b1;
                end
            end
            rrts_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_running_next = rrts_pkg::TID_W'(cur_reg);
                    m_new_next     = rrts_pkg::TID_W'(new_slot_reg);
                    m_ok_next      = ok_reg;
                    m_none_next    = none_reg;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rrts_pkg::ST_IDLE;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Per-event working registers and the result word.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        target_reg    <= target_next;
        cur_run_reg   <= cur_run_next;
        idx_reg       <= idx_next;
        step_reg      <= step_next;
        new_slot_reg  <= new_slot_next;
        ok_reg        <= ok_next;
        none_reg      <= none_next;
        m_running_reg <= m_running_next;
        m_new_reg     <= m_new_next;
        m_ok_reg      <= m_ok_next;
        m_none_reg    <= m_none_next;
    end

endmodule
